@@ src/dorf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dorf_pkg
// shared types and constants of the dual overwrite ring fifo
// ----------------------------------------------------------------------------
package dorf_pkg;

    // fixed field widths
    localparam int CAP_W       = 11;
    localparam int LEN_W       = 11;
    localparam int BYTE_W      = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // request kinds carried on tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // port and direction codes
    localparam logic [1:0] PORT_ONE = 2'd1;
    localparam logic [1:0] PORT_TWO = 2'd2;
    localparam logic [1:0] DIR_RX   = 2'd1;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NOINIT = 2'd1,
        STAT_BAD    = 2'd2,
        STAT_LONG   = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [BYTE_W-1:0]  data;
        logic               last;
    } t_result;

endpackage
`default_nettype wire

@@ src/dorf_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dorf_store
// byte store for both rings, one write and one registered read port
// ----------------------------------------------------------------------------
module dorf_store
    import dorf_pkg::*;
#(
    parameter int ADDR_W = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [BYTE_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ src/dorf_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dorf_outq
// two-entry result queue in front of the output stream
// ----------------------------------------------------------------------------
module dorf_outq
    import dorf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_push_item,
    input  wire logic    i_pop,
    output t_result      o_item,
    output logic         o_valid,
    output logic [1:0]   o_cnt
);

    t_result    r_entry [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_push_item;
        end
    end

    assign o_item  = r_entry[r_rptr];
    assign o_valid = (r_cnt != 2'd0);
    assign o_cnt   = r_cnt;

endmodule
`default_nettype wire

@@ src/dual_overwrite_ring_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_overwrite_ring_fifo
// two receive byte rings, one per port, that overwrite the oldest byte
// ----------------------------------------------------------------------------
// Two byte rings share one synchronous store, one ring per port, each with a
// capacity set through the config port (values above DEPTH saturate, writing
// a capacity empties that ring at once, so there is no clearing pass). A
// write item carries one byte of a burst; the burst is checked on its first
// byte and its last byte yields one status result. A write item is taken
// every cycle while no read runs and the result queue is not full. A read
// request is all or nothing: a failed check yields one status result, a good
// one yields length bytes oldest first, one per cycle through the store's
// single read port while the queue has room; the last byte must return from
// the store before the next item is taken. Results leave through a two-entry
// queue; an output stall holds byte reads once no entry is free for them.
// ----------------------------------------------------------------------------
module dual_overwrite_ring_fifo
    import dorf_pkg::*;
#(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // config write port
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_idx,
    input  wire logic [CAP_W-1:0]       i_cfg_data,
    // request stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // port[1:0], direction[3:2], length[14:4], data_byte[22:15], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic                   s_axis_tuser,
    // last_of_burst
    input  wire logic                   s_axis_tlast,
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status[1:0], read_byte[9:2], zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // last
    output logic                        m_axis_tlast
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int SUM_W  = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
    localparam int RD_W   = $clog2(MAX_READ + 1);
    localparam int ADDR_W = IDX_W + 1;

    // request fields
    logic [1:0]        in_port;
    logic [1:0]        in_dir;
    logic [LEN_W-1:0]  in_len;
    logic [BYTE_W-1:0] in_byte;
    logic              in_acc;

    assign in_port = s_axis_tdata[1:0];
    assign in_dir  = s_axis_tdata[3:2];
    assign in_len  = s_axis_tdata[14:4];
    assign in_byte = s_axis_tdata[22:15];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // per-port ring state
    logic [CAP_W-1:0] r_cap    [2];
    logic [CAP_W-1:0] r_fill   [2];
    logic [IDX_W-1:0] r_oldest [2];
    logic [CAP_W-1:0] n_cap    [2];
    logic [CAP_W-1:0] n_fill   [2];
    logic [IDX_W-1:0] n_oldest [2];

    // burst tracking
    logic    r_burst_active, n_burst_active;
    logic    r_burst_rej,    n_burst_rej;
    logic    r_burst_port,   n_burst_port;
    t_status r_burst_status, n_burst_status;

    // read sequencer
    t_state          r_state,     n_state;
    logic            r_rd_port,   n_rd_port;
    logic [RD_W-1:0] r_rd_left,   n_rd_left;
    logic            r_inflight,  n_inflight;
    logic            r_infl_last, n_infl_last;

    // result queue
    logic       q_push;
    t_result    q_push_item;
    logic       q_pop;
    t_result    q_item;
    logic       q_valid;
    logic [1:0] q_cnt;
    logic [1:0] q_cnt_after_pop;

    // store access
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic              st_re;
    logic [BYTE_W-1:0] st_rdata;

    // selected ring and checks
    logic             pi;
    logic             sel_port;
    logic [CAP_W-1:0] sel_cap;
    logic [CAP_W-1:0] sel_fill;
    logic [IDX_W-1:0] sel_oldest;
    logic [SUM_W-1:0] app_sum;
    logic [SUM_W-1:0] app_wrapped;
    logic [SUM_W-1:0] old_inc;
    logic [IDX_W-1:0] oldest_next;
    logic [IDX_W-1:0] app_pos;
    logic             ring_full;
    t_status          chk_status;
    t_status          wr_status;
    t_status          rd_status;
    logic             eff_rej;
    logic             issue;
    logic             cfg_sat;

    assign pi = (in_port == PORT_TWO);

    // only one ring is selected per cycle: the reader's, the burst's or the request's
    always_comb begin
        if (r_state == ST_READ) begin
            sel_port = r_rd_port;
        end else if (s_axis_tuser == REQ_WRITE && r_burst_active) begin
            sel_port = r_burst_port;
        end else begin
            sel_port = pi;
        end
    end

    assign sel_cap    = r_cap[sel_port];
    assign sel_fill   = r_fill[sel_port];
    assign sel_oldest = r_oldest[sel_port];

    // append position is (oldest + fill) mod cap, the sum stays below twice cap
    assign app_sum     = SUM_W'(sel_oldest) + SUM_W'(sel_fill);
    assign app_wrapped = (app_sum >= SUM_W'(sel_cap)) ? app_sum - SUM_W'(sel_cap) : app_sum;
    assign ring_full   = (sel_fill >= sel_cap);
    assign app_pos     = ring_full ? sel_oldest : app_wrapped[IDX_W-1:0];
    assign old_inc     = SUM_W'(sel_oldest) + SUM_W'(1);
    assign oldest_next = (old_inc == SUM_W'(sel_cap)) ? '0 : old_inc[IDX_W-1:0];

    always_comb begin
        if (in_len == '0) begin
            chk_status = STAT_BAD;
        end else if ((in_port != PORT_ONE && in_port != PORT_TWO) || in_dir != DIR_RX) begin
            chk_status = STAT_BAD;
        end else if (sel_cap == '0) begin
            chk_status = STAT_NOINIT;
        end else begin
            chk_status = STAT_OK;
        end
    end

    assign wr_status = (chk_status == STAT_OK && in_len > LEN_W'(sel_cap))
                     ? STAT_LONG : chk_status;
    assign rd_status = (chk_status == STAT_OK &&
                        (in_len > LEN_W'(MAX_READ) || in_len > LEN_W'(sel_fill)))
                     ? STAT_LONG : chk_status;
    assign eff_rej   = r_burst_active ? r_burst_rej : (wr_status != STAT_OK);

    // issue a store read only when the queue has room for the returning byte
    assign q_pop           = m_axis_tvalid && m_axis_tready;
    assign q_cnt_after_pop = q_cnt - {1'b0, q_pop};
    assign issue           = (r_state == ST_READ) &&
                             ((3'(q_cnt_after_pop) + 3'(r_inflight)) < 3'd2);

    assign s_axis_tready = (r_state == ST_IDLE) && !r_inflight && (q_cnt != 2'd2);

    assign cfg_sat = (32'(i_cfg_data) > 32'(DEPTH));

    always_comb begin
        n_cap          = r_cap;
        n_fill         = r_fill;
        n_oldest       = r_oldest;
        n_burst_active = r_burst_active;
        n_burst_rej    = r_burst_rej;
        n_burst_port   = r_burst_port;
        n_burst_status = r_burst_status;
        n_state        = r_state;
        n_rd_port      = r_rd_port;
        n_rd_left      = r_rd_left;
        n_inflight     = issue;
        n_infl_last    = issue && (r_rd_left == RD_W'(1));
        st_we          = 1'b0;
        st_re          = issue;
        q_push         = 1'b0;
        q_push_item    = '{status: STAT_OK, data: '0, last: 1'b1};

        // byte returning from the store
        if (r_inflight) begin
            q_push      = 1'b1;
            q_push_item = '{status: STAT_OK, data: st_rdata, last: r_infl_last};
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && s_axis_tuser == REQ_WRITE) begin
                    if (!r_burst_active) begin
                        n_burst_active = 1'b1;
                        n_burst_port   = pi;
                        n_burst_status = wr_status;
                        n_burst_rej    = (wr_status != STAT_OK);
                    end
                    if (!eff_rej && sel_cap != '0) begin
                        st_we = 1'b1;
                        if (ring_full) begin
                            n_oldest[sel_port] = oldest_next;
                        end else begin
                            n_fill[sel_port] = sel_fill + CAP_W'(1);
                        end
                    end
                    if (s_axis_tlast) begin
                        q_push         = 1'b1;
                        q_push_item    = '{status: r_burst_active ? r_burst_status : wr_status,
                                           data: '0, last: 1'b1};
                        n_burst_active = 1'b0;
                        n_burst_rej    = 1'b0;
                    end
                end else if (in_acc) begin
                    if (rd_status != STAT_OK) begin
                        q_push      = 1'b1;
                        q_push_item = '{status: rd_status, data: '0, last: 1'b1};
                    end else begin
                        n_fill[sel_port] = sel_fill - in_len;
                        n_rd_port        = sel_port;
                        n_rd_left        = in_len[RD_W-1:0];
                        n_state          = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (issue) begin
                    n_oldest[sel_port] = oldest_next;
                    n_rd_left          = r_rd_left - RD_W'(1);
                    if (r_rd_left == RD_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a capacity write empties that ring
        if (i_cfg_we) begin
            n_cap[i_cfg_idx]    = cfg_sat ? CAP_W'(DEPTH) : i_cfg_data;
            n_fill[i_cfg_idx]   = '0;
            n_oldest[i_cfg_idx] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 2; p++) begin
                r_cap[p]    <= '0;
                r_fill[p]   <= '0;
                r_oldest[p] <= '0;
            end
            r_burst_active <= 1'b0;
            r_burst_rej    <= 1'b0;
            r_burst_port   <= 1'b0;
            r_burst_status <= STAT_OK;
            r_state        <= ST_IDLE;
            r_rd_port      <= 1'b0;
            r_rd_left      <= '0;
            r_inflight     <= 1'b0;
            r_infl_last    <= 1'b0;
        end else begin
            r_cap          <= n_cap;
            r_fill         <= n_fill;
            r_oldest       <= n_oldest;
            r_burst_active <= n_burst_active;
            r_burst_rej    <= n_burst_rej;
            r_burst_port   <= n_burst_port;
            r_burst_status <= n_burst_status;
            r_state        <= n_state;
            r_rd_port      <= n_rd_port;
            r_rd_left      <= n_rd_left;
            r_inflight     <= n_inflight;
            r_infl_last    <= n_infl_last;
        end
    end

    assign st_waddr = {sel_port, app_pos};

    dorf_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (in_byte),
        .i_re    (st_re),
        .i_raddr ({r_rd_port, sel_oldest}),
        .o_rdata (st_rdata)
    );

    dorf_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_item (q_push_item),
        .i_pop       (q_pop),
        .o_item      (q_item),
        .o_valid     (q_valid),
        .o_cnt       (q_cnt)
    );

    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - BYTE_W - 2)'(0), q_item.data, q_item.status};
    assign m_axis_tlast  = q_item.last;

`ifndef SYNTHESIS
    // queue never overflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && !q_pop && q_cnt == 2'd2))
        else $error("result queue overflow");

    // no new item while a store read is still returning
    a_no_accept_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight |-> !in_acc)
        else $error("item accepted during store read");

    // the reader always has bytes left to fetch
    a_read_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_rd_left != '0))
        else $error("read sequencer with nothing left");

    // fill never exceeds capacity
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill[0] <= r_cap[0]) && (r_fill[1] <= r_cap[1]))
        else $error("fill count above capacity");
`endif

endmodule
`default_nettype wire
